/* hdl/rsmp_pkg.sv */
// ----------------------------------------------------------------------------
// rsmp_pkg
// Types and constants shared by the slewed-ratio linear resampler modules.
// ----------------------------------------------------------------------------
package rsmp_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 33;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO = 2'd3;

	// register reset values
	localparam logic [1:0]  CHANNEL_COUNT_RST  = 2'd2;
	localparam logic [31:0] MAX_RATIO_STEP_RST = 32'd85899;
	localparam logic [32:0] MIN_RATIO_RST      = 33'h0_8000_0000;
	localparam logic [32:0] MAX_RATIO_RST      = 33'h1_8000_0000;

	// Q1.32 constants
	localparam logic [32:0] RATIO_ONE  = 33'h1_0000_0000;
	localparam logic [32:0] RATIO_HALF = 33'h0_8000_0000;

	// rounding offsets, half away from zero
	localparam logic [31:0] RND_POS = 32'h8000_0000;
	localparam logic [31:0] RND_NEG = 32'h7FFF_FFFF;

	// request and result kinds
	localparam logic KIND_AUDIO = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_ACC,
		ST_EMIT,
		ST_FIN,
		ST_TDIFF,
		ST_TSTEP,
		ST_TEMIT
	} state_t;

	typedef struct packed {
		logic        two_ch;
		logic [31:0] step;
		logic [32:0] lo;
		logic [32:0] hi;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic prime;
		logic mul;
		logic acc;
		logic emit_audio;
		logic last;
		logic finish;
		logic tick_diff;
		logic tick_step;
		logic tick_emit;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic primed;
		logic phase_ge_one;
		logic next_ge_one;
		logic out_free;
	} status_t;

endpackage

/* hdl/slewed_ratio_linear_resampler.sv */
// ----------------------------------------------------------------------------
// slewed_ratio_linear_resampler
// Linear-interpolation sample-rate converter with a slewed Q1.32 ratio.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A source frame that only primes the block or
// produces no output goes from acceptance through a decide step back to
// ready; a frame with n outputs (1 or 2) makes one pass per output through
// the shared blend multiplier, accumulate and round steps, then finishes. A
// period tick steps through difference, slew and clamp. A result that the
// sink has not taken holds the block in its emit step; the next item is
// accepted while the last result waits in the output register. Input tdata
// carries sample_ch0, sample_ch1, target_ratio from bit 0 up, tuser carries
// req_type; output tdata carries out_ch0, out_ch1, applied_ratio, tuser
// carries result_kind and tlast marks the last result of an input beat.
module slewed_ratio_linear_resampler #(
	parameter int MAX_CHANNELS = 2,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// sample_ch0, sample_ch1, target_ratio
	input  logic [((2*SAMPLE_BITS+33+7)/8)*8-1:0] s_tdata,
	// req_type
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_ch0, out_ch1, applied_ratio
	output logic [((2*SAMPLE_BITS+33+7)/8)*8-1:0] m_tdata,
	// result_kind
	output logic                             m_tuser,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [rsmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsmp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int SB  = SAMPLE_BITS;
	localparam int FW  = 2*SB + 33;
	localparam int TDW = ((FW + 7) / 8) * 8;
	localparam int PAD = TDW - FW;

	rsmp_pkg::cfg_t    cfg;
	rsmp_pkg::cmd_t    cmd;
	rsmp_pkg::status_t sts;

	logic [SB-1:0] out_ch0;
	logic [SB-1:0] out_ch1;
	logic [32:0]   out_ratio;

	rsmp_cfg #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	rsmp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	rsmp_dp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts),
		.in_type  (s_tuser),
		.in_ch0   (s_tdata[SB-1:0]),
		.in_ch1   (s_tdata[2*SB-1:SB]),
		.in_target(s_tdata[2*SB+32:2*SB]),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.out_kind (m_tuser),
		.out_ch0  (out_ch0),
		.out_ch1  (out_ch1),
		.out_ratio(out_ratio),
		.out_last (m_tlast)
	);

	assign m_tdata = {{PAD{1'b0}}, out_ratio, out_ch1, out_ch0};

endmodule

/* hdl/rsmp_cfg.sv */
// ----------------------------------------------------------------------------
// rsmp_cfg
// Configuration register file and derived ratio bounds.
// ----------------------------------------------------------------------------
module rsmp_cfg #(
	parameter int MAX_CHANNELS = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rsmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsmp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output rsmp_pkg::cfg_t                   cfg
);

	logic [1:0]  channel_count_q;
	logic [31:0] max_ratio_step_q;
	logic [32:0] min_ratio_q;
	logic [32:0] max_ratio_q;
	logic [32:0] lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q  <= rsmp_pkg::CHANNEL_COUNT_RST;
			max_ratio_step_q <= rsmp_pkg::MAX_RATIO_STEP_RST;
			min_ratio_q      <= rsmp_pkg::MIN_RATIO_RST;
			max_ratio_q      <= rsmp_pkg::MAX_RATIO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsmp_pkg::REG_CHANNEL_COUNT:  channel_count_q  <= cfg_wdata[1:0];
				rsmp_pkg::REG_MAX_RATIO_STEP: max_ratio_step_q <= cfg_wdata[31:0];
				rsmp_pkg::REG_MIN_RATIO:      min_ratio_q      <= cfg_wdata;
				rsmp_pkg::REG_MAX_RATIO:      max_ratio_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// lower bound never below one half; upper bound never below the lower
	assign lo = (min_ratio_q < rsmp_pkg::RATIO_HALF) ? rsmp_pkg::RATIO_HALF : min_ratio_q;

	always_comb begin
		cfg.two_ch = channel_count_q[1] && (MAX_CHANNELS > 1);
		cfg.step   = max_ratio_step_q;
		cfg.lo     = lo;
		cfg.hi     = (max_ratio_q < lo) ? lo : max_ratio_q;
	end

endmodule

/* hdl/rsmp_ctrl.sv */
// ----------------------------------------------------------------------------
// rsmp_ctrl
// Sequencer: steps each accepted item through the shared blend datapath or
// the ratio slew path.
// ----------------------------------------------------------------------------
module rsmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  rsmp_pkg::status_t   sts,
	output rsmp_pkg::cmd_t      cmd
);

	rsmp_pkg::state_t state_q, state_d;
	logic n_q, n_d;  // set once the first output of a frame is out

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsmp_pkg::ST_IDLE;
			n_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		n_d      = n_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			rsmp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = rsmp_pkg::ST_DECIDE;
				end
			end
			rsmp_pkg::ST_DECIDE: begin
				n_d = 1'b0;
				if (sts.is_tick) begin
					state_d = rsmp_pkg::ST_TDIFF;
				end else if (!sts.primed) begin
					cmd.prime = 1'b1;
					state_d   = rsmp_pkg::ST_IDLE;
				end else if (sts.phase_ge_one) begin
					// frame consumed without output
					cmd.finish = 1'b1;
					state_d    = rsmp_pkg::ST_IDLE;
				end else begin
					state_d = rsmp_pkg::ST_MUL;
				end
			end
			rsmp_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = rsmp_pkg::ST_ACC;
			end
			rsmp_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = rsmp_pkg::ST_EMIT;
			end
			rsmp_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_audio = 1'b1;
					cmd.last       = n_q || sts.next_ge_one;
					if (cmd.last) begin
						state_d = rsmp_pkg::ST_FIN;
					end else begin
						n_d     = 1'b1;
						state_d = rsmp_pkg::ST_MUL;
					end
				end
			end
			rsmp_pkg::ST_FIN: begin
				cmd.finish = 1'b1;
				state_d    = rsmp_pkg::ST_IDLE;
			end
			rsmp_pkg::ST_TDIFF: begin
				cmd.tick_diff = 1'b1;
				state_d       = rsmp_pkg::ST_TSTEP;
			end
			rsmp_pkg::ST_TSTEP: begin
				cmd.tick_step = 1'b1;
				state_d       = rsmp_pkg::ST_TEMIT;
			end
			rsmp_pkg::ST_TEMIT: begin
				if (sts.out_free) begin
					cmd.tick_emit = 1'b1;
					state_d       = rsmp_pkg::ST_IDLE;
				end
			end
			default: state_d = rsmp_pkg::ST_IDLE;
		endcase
	end

	a_blend_phase_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |-> !sts.phase_ge_one)
		else $error("blend started with phase at or above one");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_audio || cmd.tick_emit) |-> sts.out_free)
		else $error("result loaded while output register still full");

	a_accept_then_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == rsmp_pkg::ST_DECIDE))
		else $error("accepted beat not followed by decode");

	a_prime_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prime |-> (!sts.primed && !sts.is_tick))
		else $error("prime issued on a primed block or a tick");

endmodule

/* hdl/rsmp_dp.sv */
// ----------------------------------------------------------------------------
// rsmp_dp
// Datapath: input capture, phase and ratio state, blend multiply and
// rounding lanes, ratio slew and clamp, output register.
// ----------------------------------------------------------------------------
module rsmp_dp #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rsmp_pkg::cfg_t          cfg,
	input  rsmp_pkg::cmd_t          cmd,
	output rsmp_pkg::status_t       sts,
	input  logic                    in_type,
	input  logic [SAMPLE_BITS-1:0]  in_ch0,
	input  logic [SAMPLE_BITS-1:0]  in_ch1,
	input  logic [32:0]             in_target,
	input  logic                    m_tready,
	output logic                    m_tvalid,
	output logic                    out_kind,
	output logic [SAMPLE_BITS-1:0]  out_ch0,
	output logic [SAMPLE_BITS-1:0]  out_ch1,
	output logic [32:0]             out_ratio,
	output logic                    out_last
);

	localparam int SB = SAMPLE_BITS;
	localparam int PW = SB + 34;  // product width
	localparam int SW = SB + 35;  // accumulator width

	logic                 type_q;
	logic                 two_ch_q;
	logic [32:0]          tgt_q;
	logic signed [SB-1:0] cur_q  [2];
	logic signed [SB-1:0] prev_q [2];
	logic                 primed_q;
	logic [33:0]          phase_q;
	logic [32:0]          ratio_q;

	logic signed [SB:0]   diff    [2];
	logic signed [PW-1:0] prod_s1 [2];
	logic [SW-1:0]        sum_s2  [2];
	logic [SW-1:0]        rsum    [2];
	logic [SB-1:0]        blend   [2];

	logic [33:0] phase_sum;
	logic        tgt_gt;
	logic        tgt_gt_q;
	logic [32:0] tdiff_q;
	logic [32:0] delta;
	logic [33:0] rnew_q;
	logic [32:0] clamped;
	logic        m_tvalid_q;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q   <= in_type;
			two_ch_q <= cfg.two_ch;
			tgt_q    <= in_target;
			cur_q[0] <= in_ch0;
			cur_q[1] <= cfg.two_ch ? in_ch1 : '0;
		end
	end

	// previous frame
	always_ff @(posedge clk) begin
		if (cmd.prime || cmd.finish) begin
			prev_q[0] <= cur_q[0];
			prev_q[1] <= cur_q[1];
		end
	end

	assign phase_sum = phase_q + {1'b0, ratio_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			phase_q  <= '0;
			ratio_q  <= rsmp_pkg::RATIO_ONE;
		end else begin
			if (cmd.prime)
				primed_q <= 1'b1;
			if (cmd.emit_audio) begin
				phase_q <= phase_sum;
			end else if (cmd.finish && (phase_q[33:32] != 2'd0)) begin
				phase_q <= {phase_q[33:32] - 2'd1, phase_q[31:0]};
			end
			if (cmd.tick_emit)
				ratio_q <= clamped;
		end
	end

	// blend lanes: prev + (cur - prev) * frac, rounded half away from zero
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			diff[l]  = {cur_q[l][SB-1], cur_q[l]} - {prev_q[l][SB-1], prev_q[l]};
			rsum[l]  = sum_s2[l] + {{(SW-32){1'b0}},
				(sum_s2[l][SW-1] ? rsmp_pkg::RND_NEG : rsmp_pkg::RND_POS)};
			blend[l] = rsum[l][SB+31:32];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			if (cmd.mul)
				prod_s1[l] <= diff[l] * $signed({1'b0, phase_q[31:0]});
			if (cmd.acc)
				sum_s2[l] <= {{3{prev_q[l][SB-1]}}, prev_q[l], 32'h0}
					+ {prod_s1[l][PW-1], prod_s1[l]};
		end
	end

	// ratio slew toward the target, then clamp
	assign tgt_gt = tgt_q > ratio_q;
	assign delta  = (tdiff_q > {1'b0, cfg.step}) ? {1'b0, cfg.step} : tdiff_q;

	always_ff @(posedge clk) begin
		if (cmd.tick_diff) begin
			tgt_gt_q <= tgt_gt;
			tdiff_q  <= tgt_gt ? (tgt_q - ratio_q) : (ratio_q - tgt_q);
		end
		if (cmd.tick_step)
			rnew_q <= tgt_gt_q ? ({1'b0, ratio_q} + {1'b0, delta})
				: ({1'b0, ratio_q} - {1'b0, delta});
	end

	// lo <= hi, so the two compares are independent
	always_comb begin
		if (rnew_q < {1'b0, cfg.lo})
			clamped = cfg.lo;
		else if (rnew_q > {1'b0, cfg.hi})
			clamped = cfg.hi;
		else
			clamped = rnew_q[32:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.emit_audio || cmd.tick_emit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_audio) begin
			out_kind  <= rsmp_pkg::KIND_AUDIO;
			out_ch0   <= blend[0];
			out_ch1   <= two_ch_q ? blend[1] : '0;
			out_ratio <= ratio_q;
			out_last  <= cmd.last;
		end else if (cmd.tick_emit) begin
			out_kind  <= rsmp_pkg::KIND_TICK;
			out_ch0   <= '0;
			out_ch1   <= '0;
			out_ratio <= clamped;
			out_last  <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		sts.is_tick      = (type_q == rsmp_pkg::KIND_TICK);
		sts.primed       = primed_q;
		sts.phase_ge_one = (phase_q[33:32] != 2'd0);
		sts.next_ge_one  = (phase_sum[33:32] != 2'd0);
		sts.out_free     = !m_tvalid_q || m_tready;
	end

endmodule

/* test/slewed_ratio_linear_resampler_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slewed_ratio_linear_resampler_tb
// Self-checking bench for the linear resampler. A short table of directed
// beats is followed by random frames and period ticks under several register
// settings. Every accepted input beat runs through an in-bench model of the
// blend, phase and ratio slew, and each output beat is compared field by
// field with the oldest predicted one. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module slewed_ratio_linear_resampler_tb;

	localparam int DW          = ((2*16+33+7)/8)*8;
	localparam int PAD_W       = DW - 65;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 16;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_ITEMS = 255;

	localparam longint unsigned ONE_Q    = 64'(rsmp_pkg::RATIO_ONE);
	localparam longint unsigned HALF_Q   = 64'(rsmp_pkg::RATIO_HALF);
	localparam longint unsigned MASK34_Q = 64'h3_FFFF_FFFF;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] ch0;
		logic signed [15:0] ch1;
		logic [32:0]        target;
	} req_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] ch0;
		logic signed [15:0] ch1;
		logic [32:0]        ratio;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [32:0] cc_w;
		logic [32:0] step_w;
		logic [32:0] min_w;
		logic [32:0] max_w;
	} cfg_set_t;

	typedef struct {
		int      cfg_sel;
		req_t    item;
		int      n_fixed;
		result_t fixed;
	} dir_row_t;

	logic            clk;
	logic            arst_n    = 1'b0;
	logic            s_tvalid  = 1'b0;
	logic            s_tready;
	// sample_ch0, sample_ch1, target_ratio
	logic [DW-1:0]   s_tdata   = '0;
	// req_type
	logic            s_tuser   = 1'b0;
	logic            m_tvalid;
	logic            m_tready  = 1'b0;
	// out_ch0, out_ch1, applied_ratio
	logic [DW-1:0]   m_tdata;
	// result_kind
	logic            m_tuser;
	logic            m_tlast;
	logic            cfg_we    = 1'b0;
	logic [rsmp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rsmp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	// model state and register shadow
	longint          hist0, hist1;
	bit              primed_q;
	longint unsigned phase_acc, ratio_now;
	logic [1:0]      chan_q;
	longint unsigned step_q, min_ratio_q, max_ratio_q;

	result_t  awaited_outputs[$];
	dir_row_t stim_table[$];
	cfg_set_t dir_cfg[4];

	int  src_idle_pct, snk_idle_pct;
	bit  sink_hold_req = 1'b0;
	int  hold_left     = 0;
	int  mismatches    = 0;
	int  results_seen  = 0;
	int  items_sent    = 0;
	int  ticks_sent    = 0;
	int  silent_frames = 0;
	int  twin_frames   = 0;
	int  settings_used = 0;

	slewed_ratio_linear_resampler #(
		.MAX_CHANNELS(2),
		.SAMPLE_BITS (16)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// prev + (cur - prev) * frac in Q32, rounded half away from zero
	function automatic logic [15:0] lerp_q32(input longint a, input longint b,
			input longint frac);
		longint acc, mag;
		acc = (a <<< 32) + (b - a) * frac;
		if (acc >= 0) begin
			mag = (acc + 64'sh8000_0000) >>> 32;
			return mag[15:0];
		end
		mag = (-acc + 64'sh8000_0000) >>> 32;
		mag = -mag;
		return mag[15:0];
	endfunction

	function automatic int advance_resampler(input req_t it, output result_t ra,
			output result_t rb);
		longint unsigned lo, hi, r, tgt, gap;
		longint          cur0, cur1;
		bit              stereo;
		int              n;
		result_t         res[2];
		ra = '0;
		rb = '0;
		res[0] = '0;
		res[1] = '0;
		n = 0;
		if (it.kind == rsmp_pkg::KIND_TICK) begin
			tgt = longint'(it.target);
			lo = (min_ratio_q < HALF_Q) ? HALF_Q : min_ratio_q;
			hi = (max_ratio_q < lo) ? lo : max_ratio_q;
			r = ratio_now;
			if (tgt > r) begin
				gap = tgt - r;
				r = r + ((gap > step_q) ? step_q : gap);
			end else begin
				gap = r - tgt;
				r = r - ((gap > step_q) ? step_q : gap);
			end
			if (r < lo)
				r = lo;
			if (r > hi)
				r = hi;
			ratio_now = r;
			ra.kind  = rsmp_pkg::KIND_TICK;
			ra.ratio = r[32:0];
			ra.last  = 1'b1;
			return 1;
		end
		stereo = (chan_q >= 2'd2);
		cur0 = longint'(it.ch0);
		cur1 = stereo ? longint'(it.ch1) : 64'sd0;
		if (!primed_q) begin
			hist0 = cur0;
			hist1 = cur1;
			primed_q = 1'b1;
			return 0;
		end
		while (phase_acc < ONE_Q && n < 2) begin
			res[n].kind  = rsmp_pkg::KIND_AUDIO;
			res[n].ch0   = lerp_q32(hist0, cur0, longint'(phase_acc));
			res[n].ch1   = stereo ? lerp_q32(hist1, cur1, longint'(phase_acc)) : 16'd0;
			res[n].ratio = ratio_now[32:0];
			res[n].last  = 1'b0;
			phase_acc = (phase_acc + ratio_now) & MASK34_Q;
			n++;
		end
		if (n > 0)
			res[n-1].last = 1'b1;
		if (phase_acc >= ONE_Q)
			phase_acc = phase_acc - ONE_Q;
		hist0 = cur0;
		hist1 = cur1;
		ra = res[0];
		rb = res[1];
		return n;
	endfunction

	function automatic logic signed [15:0] pick_sample();
		logic [15:0] v;
		case ($urandom_range(9))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2, 3: v = 16'($urandom_range(15)) - 16'd8;
			default: v = 16'($urandom());
		endcase
		return v;
	endfunction

	function automatic req_t random_item();
		req_t it;
		it.kind = ($urandom_range(99) < 12) ? rsmp_pkg::KIND_TICK : rsmp_pkg::KIND_AUDIO;
		it.ch0  = pick_sample();
		it.ch1  = pick_sample();
		case ($urandom_range(7))
			0: it.target = '0;
			1: it.target = '1;
			2, 3: it.target = {1'($urandom_range(1)), $urandom()};
			// near the ratio in use, the usual case for a drift correction
			default: it.target = 33'(ratio_now + 64'($urandom_range(400000)) - 64'd200000);
		endcase
		return it;
	endfunction

	function automatic logic [32:0] pick_bound();
		case ($urandom_range(5))
			0: return rsmp_pkg::RATIO_HALF;
			1: return rsmp_pkg::MAX_RATIO_RST;
			2: return rsmp_pkg::RATIO_ONE;
			3: return 33'($urandom_range(32'h7FFF_FFFF));
			default: return rsmp_pkg::RATIO_HALF + {1'b0, $urandom()};
		endcase
	endfunction

	function automatic cfg_set_t pick_settings();
		cfg_set_t    c;
		logic [31:0] s;
		case ($urandom_range(4))
			0: s = '0;
			1: s = '1;
			2: s = $urandom_range(100000, 1);
			3: s = $urandom();
			default: s = rsmp_pkg::MAX_RATIO_STEP_RST;
		endcase
		// unused upper bits carry junk, the block keeps only the register width
		c.cc_w   = {31'($urandom()), 2'($urandom_range(3))};
		c.step_w = {1'($urandom_range(1)), s};
		c.min_w  = pick_bound();
		c.max_w  = pick_bound();
		return c;
	endfunction

	function automatic void add_row(input int sel, input logic kind,
			input logic signed [15:0] c0, input logic signed [15:0] c1,
			input logic [32:0] tgt, input int nfix, input logic fk,
			input logic signed [15:0] f0, input logic signed [15:0] f1,
			input logic [32:0] fr);
		dir_row_t row;
		row.cfg_sel      = sel;
		row.item.kind    = kind;
		row.item.ch0     = c0;
		row.item.ch1     = c1;
		row.item.target  = tgt;
		row.n_fixed      = nfix;
		row.fixed.kind   = fk;
		row.fixed.ch0    = f0;
		row.fixed.ch1    = f1;
		row.fixed.ratio  = fr;
		row.fixed.last   = 1'b1;
		stim_table.push_back(row);
	endfunction

	task automatic write_reg(input logic [rsmp_pkg::CFG_IDX_W-1:0] idx,
			input logic [32:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			rsmp_pkg::REG_CHANNEL_COUNT:  chan_q = val[1:0];
			rsmp_pkg::REG_MAX_RATIO_STEP: step_q = 64'(val[31:0]);
			rsmp_pkg::REG_MIN_RATIO:      min_ratio_q = 64'(val);
			rsmp_pkg::REG_MAX_RATIO:      max_ratio_q = 64'(val);
			default: ;
		endcase
	endtask

	task automatic apply_settings(input cfg_set_t c);
		write_reg(rsmp_pkg::REG_CHANNEL_COUNT, c.cc_w);
		write_reg(rsmp_pkg::REG_MAX_RATIO_STEP, c.step_w);
		write_reg(rsmp_pkg::REG_MIN_RATIO, c.min_w);
		write_reg(rsmp_pkg::REG_MAX_RATIO, c.max_w);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// stop offering, drain every predicted beat, then let a silent frame finish
	task automatic wait_quiet();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic offer_item(input req_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{PAD_W{1'b0}}, it.target, it.ch1, it.ch0};
		s_tuser  <= it.kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// nfix < 0: model decides; otherwise the typed-in beats are expected
	task automatic run_item(input req_t it, input int nfix, input result_t fixed);
		result_t ra, rb;
		int      n;
		offer_item(it);
		n = advance_resampler(it, ra, rb);
		if (nfix < 0) begin
			if (n > 0)
				awaited_outputs.push_back(ra);
			if (n > 1)
				awaited_outputs.push_back(rb);
		end else if (nfix > 0) begin
			awaited_outputs.push_back(fixed);
		end
		items_sent++;
		if (it.kind == rsmp_pkg::KIND_TICK)
			ticks_sent++;
		else if (n == 0)
			silent_frames++;
		else if (n == 2)
			twin_frames++;
	endtask

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_result();
		result_t want;
		if (awaited_outputs.size() == 0) begin
			$error("output beat with nothing predicted: kind %0d ratio %0d",
				m_tuser, m_tdata[64:32]);
			mismatches++;
			return;
		end
		want = awaited_outputs.pop_front();
		check_field("result_kind", longint'(want.kind), longint'(m_tuser));
		check_field("out_ch0", longint'(want.ch0), longint'($signed(m_tdata[15:0])));
		check_field("out_ch1", longint'(want.ch1), longint'($signed(m_tdata[31:16])));
		check_field("applied_ratio", longint'(want.ratio), longint'(m_tdata[64:32]));
		check_field("last_of_run", longint'(want.last), longint'(m_tlast));
		results_seen++;
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_result();
		if (sink_hold_req) begin
			hold_left = HOLD_CYCLES;
			sink_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				stalled = 0;
			else
				stalled++;
		end
		$display("FAIL slewed_ratio_linear_resampler");
		$finish;
	end

	initial begin
		result_t none;
		none = '0;
		chan_q      = rsmp_pkg::CHANNEL_COUNT_RST;
		step_q      = 64'(rsmp_pkg::MAX_RATIO_STEP_RST);
		min_ratio_q = 64'(rsmp_pkg::MIN_RATIO_RST);
		max_ratio_q = 64'(rsmp_pkg::MAX_RATIO_RST);
		hist0       = 0;
		hist1       = 0;
		primed_q    = 1'b0;
		phase_acc   = 0;
		ratio_now   = ONE_Q;
		src_idle_pct = 29;
		snk_idle_pct = 86;

		dir_cfg[0] = '{33'd2, 33'h0_FFFF_FFFF, rsmp_pkg::RATIO_HALF, rsmp_pkg::MAX_RATIO_RST};
		// max below min: the lower bound wins
		dir_cfg[1] = '{33'd1, 33'h0_FFFF_FFFF, rsmp_pkg::MAX_RATIO_RST, rsmp_pkg::RATIO_HALF};
		// channel count zero acts as mono, min below one half is raised
		dir_cfg[2] = '{33'd0, 33'd0, 33'd0, rsmp_pkg::MAX_RATIO_RST};
		// channel count three acts as stereo
		dir_cfg[3] = '{33'd3, 33'(rsmp_pkg::MAX_RATIO_STEP_RST), rsmp_pkg::RATIO_HALF,
			rsmp_pkg::MAX_RATIO_RST};

		// reset settings: ratio one, phase zero
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sh8000, 16'sh7FFF, '0, 0,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sh7FFF, 16'sh8000, '0, 1,
			rsmp_pkg::KIND_AUDIO, 16'sh8000, 16'sh7FFF, rsmp_pkg::RATIO_ONE);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sd0, 16'sd0, '1, 1,
			rsmp_pkg::KIND_AUDIO, 16'sh7FFF, 16'sh8000, rsmp_pkg::RATIO_ONE);
		add_row(-1, rsmp_pkg::KIND_TICK, 16'sd1234, -16'sd1234, rsmp_pkg::RATIO_ONE, 1,
			rsmp_pkg::KIND_TICK, '0, '0, rsmp_pkg::RATIO_ONE);
		add_row(-1, rsmp_pkg::KIND_TICK, 16'sd0, 16'sd0, '0, 1,
			rsmp_pkg::KIND_TICK, '0, '0,
			rsmp_pkg::RATIO_ONE - 33'(rsmp_pkg::MAX_RATIO_STEP_RST));
		add_row(-1, rsmp_pkg::KIND_TICK, 16'sd0, 16'sd0, '1, -1,
			rsmp_pkg::KIND_TICK, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sd1000, -16'sd1000, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		// full step: ratio drops straight to one half, two outputs per frame
		add_row(0, rsmp_pkg::KIND_TICK, 16'sd0, 16'sd0, '0, 1,
			rsmp_pkg::KIND_TICK, '0, '0, rsmp_pkg::RATIO_HALF);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sd1, -16'sd1, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sd0, 16'sd0, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sh8000, 16'sh7FFF, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sh7FFF, 16'sh8000, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		// one full step up from one half lands just short of 1.5
		add_row(-1, rsmp_pkg::KIND_TICK, 16'sd0, 16'sd0, '1, 1,
			rsmp_pkg::KIND_TICK, '0, '0, rsmp_pkg::MAX_RATIO_RST - 33'd1);
		// ratio near 1.5: some frames are consumed silently
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sd5, 16'sd7, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_AUDIO, -16'sd5, -16'sd7, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sd123, -16'sd456, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(1, rsmp_pkg::KIND_AUDIO, 16'sd300, 16'sd12345, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_TICK, 16'sd0, 16'sd0, '0, 1,
			rsmp_pkg::KIND_TICK, '0, '0, rsmp_pkg::MAX_RATIO_RST);
		add_row(-1, rsmp_pkg::KIND_AUDIO, -16'sd300, 16'sh8000, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(2, rsmp_pkg::KIND_TICK, 16'sd0, 16'sd0, '0, 1,
			rsmp_pkg::KIND_TICK, '0, '0, rsmp_pkg::MAX_RATIO_RST);
		add_row(-1, rsmp_pkg::KIND_AUDIO, 16'sd77, 16'sd88, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(3, rsmp_pkg::KIND_AUDIO, 16'sd111, -16'sd222, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_TICK, 16'sd0, 16'sd0, rsmp_pkg::RATIO_ONE, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);
		add_row(-1, rsmp_pkg::KIND_AUDIO, -16'sd1, 16'sd1, '0, -1,
			rsmp_pkg::KIND_AUDIO, '0, '0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			if (stim_table[i].cfg_sel >= 0) begin
				wait_quiet();
				apply_settings(dir_cfg[stim_table[i].cfg_sel]);
			end
			run_item(stim_table[i].item, stim_table[i].n_fixed, stim_table[i].fixed);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			src_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 86 : 0;
			snk_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 29 : 0;
			wait_quiet();
			apply_settings(pick_settings());
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// sink goes deaf for a while, the input side backs up
				if (ph == 1 && k == 60)
					sink_hold_req = 1'b1;
				if (ph == 3 && k == 120)
					wait_quiet();
				run_item(random_item(), -1, none);
			end
		end

		wait_quiet();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d input beats (%0d period ticks) over %0d register settings",
			items_sent, ticks_sent, settings_used);
		$display("Checked %0d output beats; %0d frames gave none, %0d gave two",
			results_seen, silent_frames, twin_frames);
		if (mismatches == 0 && awaited_outputs.size() == 0)
			$display("PASS slewed_ratio_linear_resampler");
		else
			$display("FAIL slewed_ratio_linear_resampler");
		$finish;
	end

endmodule

/* sim.f */
hdl/rsmp_pkg.sv
hdl/rsmp_cfg.sv
hdl/rsmp_ctrl.sv
hdl/rsmp_dp.sv
hdl/slewed_ratio_linear_resampler.sv
test/slewed_ratio_linear_resampler_tb.sv
